@@ sv/salc_pkg.sv @@
// Package for the set-associative LRU cache tag store: sizes, types and codes.
package salc_pkg;

    localparam int SET_BITS = 8;
    localparam int WAYS = 4;
    localparam int NSETS = 1 << SET_BITS;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W = $clog2(WAYS + 1);
    localparam int ADDR_W = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W = 48;
    localparam int OFF_W = 4;
    localparam int IDX_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam int SHAMT_W = 5;
    localparam logic [OFF_W-1:0] MAX_OFFSET_BITS = OFF_W'(12);
    localparam logic [IDX_W-1:0] MAX_SET_WIDTH = IDX_W'(SET_BITS);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED = 2'd2;

    typedef struct packed {
        logic [SET_BITS-1:0] set;
        logic [ADDR_W-1:0] tag;
        logic [NW_W-1:0] nw;
    } t_item;

    typedef struct packed {
        logic [WAYS-1:0] valid;
        logic [WAYS-1:0][ADDR_W-1:0] tag;
        logic [WAYS-1:0][STAMP_W-1:0] stamp;
    } t_row;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK
    } t_back_state;

endpackage

@@ sv/set_assoc_lru_cache_tags.sv @@
// Top level of the set-associative LRU cache tag store.
// Input channel: i_in_valid / o_in_stall carry one byte address (i_addr) per
// transaction. Output channel: o_out_valid / i_out_stall carry hit, way and
// three saturating 48-bit totals (accesses, hits, misses including this one).
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 offset_bits, 1 set index width, 2 ways_used); index 3 is ignored. Write
// only while no transaction is in flight.
// The front decodes set and tag and pushes into a two-entry queue; the back
// reads one 256-row tag memory row (all ways), compares, updates and writes it.
// An accepted address goes through the queue, the row read (BK_IDLE) and the
// compare and write-back (BK_LOOK) before its result is registered; the back
// takes no new transaction until the read-modify-write of that row is done.
// Reset: counters, clock and config return to defaults, then a clearing pass
// zeroes all 256 rows of the tag memory; o_in_stall is high during that pass.
// A stalled result holds its payload; the back waits, the queue fills, and
// then o_in_stall rises.
module set_assoc_lru_cache_tags (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic [salc_pkg::ADDR_W-1:0] i_addr,
    output logic o_out_valid,
    input  logic i_out_stall,
    output logic o_hit,
    output logic [salc_pkg::WAY_W-1:0] o_way,
    output logic [salc_pkg::CNT_W-1:0] o_access_total,
    output logic [salc_pkg::CNT_W-1:0] o_hit_total,
    output logic [salc_pkg::CNT_W-1:0] o_miss_total
);
    import salc_pkg::*;

    t_item w_item;
    t_item w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    logic w_clearing;

    salc_front u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_addr(i_addr),
        .i_busy(w_full || w_clearing),
        .o_in_stall(o_in_stall),
        .o_push(w_push),
        .o_item(w_item)
    );

    salc_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_item(w_item),
        .i_pop(w_pop),
        .o_full(w_full),
        .o_empty(w_empty),
        .o_head(w_head)
    );

    salc_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(w_empty),
        .i_head(w_head),
        .o_pop(w_pop),
        .o_clearing(w_clearing),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_hit(o_hit),
        .o_way(o_way),
        .o_access_total(o_access_total),
        .o_hit_total(o_hit_total),
        .o_miss_total(o_miss_total)
    );

endmodule

@@ sv/salc_front.sv @@
// Front end: configuration registers, address decode into set and tag.
module salc_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic i_in_valid,
    input  logic [salc_pkg::ADDR_W-1:0] i_addr,
    input  logic i_busy,
    output logic o_in_stall,
    output logic o_push,
    output salc_pkg::t_item o_item
);
    import salc_pkg::*;

    logic [OFF_W-1:0] r_offset_bits;
    logic [IDX_W-1:0] r_set_width;
    logic [2:0] r_ways_used;
    logic [OFF_W-1:0] w_ob;
    logic [IDX_W-1:0] w_ib;
    logic [SHAMT_W-1:0] w_tag_sh;
    logic [ADDR_W-1:0] w_shifted;
    logic [SET_BITS:0] w_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= OFF_W'(4);
            r_set_width <= IDX_W'(8);
            r_ways_used <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFF_W-1:0];
                CFG_SET_WIDTH: r_set_width <= i_cfg_data[IDX_W-1:0];
                CFG_WAYS_USED: r_ways_used <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ob = (r_offset_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : r_offset_bits;
        w_ib = (r_set_width > MAX_SET_WIDTH) ? MAX_SET_WIDTH : r_set_width;
        w_tag_sh = SHAMT_W'(w_ob) + SHAMT_W'(w_ib);
        w_shifted = i_addr >> w_ob;
        w_mask = ((SET_BITS+1)'(1) << w_ib) - (SET_BITS+1)'(1);
        o_item.set = w_shifted[SET_BITS-1:0] & w_mask[SET_BITS-1:0];
        o_item.tag = i_addr >> w_tag_sh;
        if (r_ways_used == 3'd0) begin
            o_item.nw = NW_W'(1);
        end else if (32'(r_ways_used) > WAYS) begin
            o_item.nw = NW_W'(WAYS);
        end else begin
            o_item.nw = NW_W'(r_ways_used);
        end
    end

    assign o_in_stall = i_busy;
    assign o_push = i_in_valid && !i_busy;

endmodule

@@ sv/salc_queue.sv @@
// Two-entry queue of decoded transactions between front and back.
module salc_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  salc_pkg::t_item i_item,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output salc_pkg::t_item o_head
);
    import salc_pkg::*;

    t_item r_mem [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head = r_mem[r_rp];

endmodule

@@ sv/salc_back.sv @@
// Back end: tag memory, lookup, LRU victim choice, counters and result register.
module salc_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  salc_pkg::t_item i_head,
    output logic o_pop,
    output logic o_clearing,
    output logic o_out_valid,
    input  logic i_out_stall,
    output logic o_hit,
    output logic [salc_pkg::WAY_W-1:0] o_way,
    output logic [salc_pkg::CNT_W-1:0] o_access_total,
    output logic [salc_pkg::CNT_W-1:0] o_hit_total,
    output logic [salc_pkg::CNT_W-1:0] o_miss_total
);
    import salc_pkg::*;

    t_row r_mem [NSETS];
    t_row r_row;
    t_row n_row;
    t_item r_item;
    t_back_state r_state;
    t_back_state n_state;
    logic [SET_BITS-1:0] r_clr_idx;
    logic [STAMP_W-1:0] r_clock;
    logic [CNT_W-1:0] r_acc;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_miss;
    logic r_out_valid;
    logic r_hit;
    logic [WAY_W-1:0] r_way;
    logic w_done;
    logic w_hit;
    logic w_have_inv;
    logic [WAY_W-1:0] w_way;
    logic [WAY_W-1:0] w_hit_way;
    logic [WAY_W-1:0] w_inv_way;
    logic [WAY_W-1:0] w_lru_way;
    logic [STAMP_W-1:0] w_best;
    logic w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_hit = 1'b0;
        w_hit_way = '0;
        w_have_inv = 1'b0;
        w_inv_way = '0;
        w_lru_way = '0;
        w_best = STAMP_MAX;
        for (int w = 0; w < WAYS; w++) begin
            if (w < 32'(r_item.nw)) begin
                if (!w_hit && r_row.valid[w] && r_row.tag[w] == r_item.tag) begin
                    w_hit = 1'b1;
                    w_hit_way = WAY_W'(w);
                end
                if (!w_have_inv && !r_row.valid[w]) begin
                    w_have_inv = 1'b1;
                    w_inv_way = WAY_W'(w);
                end
                if (r_row.stamp[w] < w_best) begin
                    w_best = r_row.stamp[w];
                    w_lru_way = WAY_W'(w);
                end
            end
        end
        w_way = w_hit ? w_hit_way : (w_have_inv ? w_inv_way : w_lru_way);
        n_row = r_row;
        n_row.valid[w_way] = 1'b1;
        n_row.tag[w_way] = r_item.tag;
        n_row.stamp[w_way] = r_clock + STAMP_W'(1);
    end

    always_comb begin
        n_state = r_state;
        o_pop = 1'b0;
        w_done = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                if (r_clr_idx == SET_BITS'(NSETS - 1)) n_state = BK_IDLE;
            end
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_state = BK_LOOK;
                end
            end
            BK_LOOK: begin
                if (w_out_free) begin
                    w_done = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
            r_clr_idx <= '0;
            r_clock <= '0;
            r_acc <= '0;
            r_hits <= '0;
            r_miss <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) r_clr_idx <= r_clr_idx + SET_BITS'(1);
            if (w_done) begin
                r_clock <= r_clock + STAMP_W'(1);
                r_acc <= (r_acc == CNT_MAX) ? r_acc : r_acc + CNT_W'(1);
                if (w_hit) r_hits <= (r_hits == CNT_MAX) ? r_hits : r_hits + CNT_W'(1);
                else r_miss <= (r_miss == CNT_MAX) ? r_miss : r_miss + CNT_W'(1);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
            r_row <= r_mem[i_head.set];
        end
        if (r_state == BK_CLEAR) begin
            r_mem[r_clr_idx] <= '0;
        end else if (w_done) begin
            r_mem[r_item.set] <= n_row;
        end
        if (w_done) begin
            r_hit <= w_hit;
            r_way <= w_way;
        end
    end

    assign o_clearing = (r_state == BK_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_hit = r_hit;
    assign o_way = r_way;
    assign o_access_total = r_acc;
    assign o_hit_total = r_hits;
    assign o_miss_total = r_miss;

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_CLEAR |-> !r_out_valid) else $error("result during clear");
    a_pop_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == BK_IDLE && !i_empty) else $error("pop outside idle");
    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_out_valid) else $error("result lost");
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_clock == $past(r_clock) + STAMP_W'(1)) else $error("clock skip");
    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && r_acc < CNT_MAX - CNT_W'(1) |=> r_acc == $past(r_acc) + CNT_W'(1))
        else $error("access count");

endmodule
